### design/sofov_pkg.sv
// Shared types and constants for the sky object field-of-view screen.
// Holds the angle units, the configuration record and the cosine series
// used to build the cosine table and the cone threshold. No dependencies.
package sofov_pkg;

    // angle units are 1/64 degree
    localparam int QUARTER_TURN       = 5760;
    localparam int HALF_TURN          = 11520;
    localparam int FULL_TURN          = 23040;
    // half width of the fixed 80 degree view, in angle units
    localparam int FOV_UNITS          = 2560;
    localparam int SCALE_NEAR_RANGE_M = 200000;
    localparam int KM_TO_M            = 1000;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // cosine values in Q1.30, never negative, at most 1.0
    localparam int COS_W = 31;
    typedef logic [COS_W-1:0] cos_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_RANGE_KM  = 2'd0,
        CFG_MIN_RANGE_KM  = 2'd1,
        CFG_RADIUS_PIXELS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] max_range_km;
        logic [15:0] min_range_km;
        logic [11:0] radius_pixels;
    } sofov_cfg_t;

    // truncated Horner series of cos to the x^14 term, Q30, floored at zero;
    // evaluated at elaboration only
    function automatic cos_t cos_series(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        p  = ((x2 * t) >> 30) / 64'd182;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 64'd132;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 64'd90;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 64'd56;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 64'd30;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 64'd12;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p  = ((x2 * t) >> 30) / 64'd2;
        t  = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        return t[COS_W-1:0];
    endfunction

    // cos(40 deg) from the same series
    localparam cos_t CONE_THRESHOLD = cos_series((HALF_PI_Q30 * 64'd4) / 64'd9);

endpackage

### design/sofov_angle_idx.sv
// Angle folding and cosine table index, three register stages.
// Depends on sofov_pkg for angle units.
module sofov_angle_idx
    import sofov_pkg::*;
#(
    parameter int COS_TABLE_ENTRIES = 1024
)(
    input  logic                                         clk,
    input  logic signed [14:0]                           angle,
    output logic [$clog2(COS_TABLE_ENTRIES + 1)-1:0]     idx,
    output logic                                         neg
);

    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1);
    // q*N + half quarter turn, before rounding division by a quarter turn
    localparam int QN_W  = $clog2(QUARTER_TURN * COS_TABLE_ENTRIES + QUARTER_TURN / 2 + 1);
    // a quarter turn is 128 * 45: shift by 7, then reciprocal of 45
    localparam int DIV_SHIFT     = 7;
    localparam int W_W           = QN_W - DIV_SHIFT;
    localparam logic [63:0] RECIP45 = 64'd95443718;
    localparam int RECIP45_W     = 27;
    localparam int RECIP45_SHIFT = 32;
    localparam int PW = (W_W + RECIP45_W > RECIP45_SHIFT + IDX_W) ?
                        W_W + RECIP45_W : RECIP45_SHIFT + IDX_W;

    logic signed [15:0] a_ext;
    logic [14:0]        r_mod;
    logic [14:0]        r_half;
    logic [12:0]        q_next;
    logic               neg_next;
    logic [12:0]        q_reg;
    logic               neg1_reg;
    logic [QN_W-1:0]    v;
    logic [W_W-1:0]     w_reg;
    logic               neg2_reg;
    logic [PW-1:0]      qp;
    logic [IDX_W-1:0]   idx_reg;
    logic               neg3_reg;

    // stage 1: reduce to one turn, fold to a half turn, mirror about 90 degrees
    always_comb
    begin
        a_ext = 16'(angle);
        if (a_ext < 0)
        begin
            r_mod = 15'(a_ext + 16'(FULL_TURN));
        end
        else
        begin
            r_mod = 15'(a_ext);
        end
        r_half = (r_mod > 15'(HALF_TURN)) ? 15'(FULL_TURN) - r_mod : r_mod;
        if (r_half > 15'(QUARTER_TURN))
        begin
            q_next   = 13'(15'(HALF_TURN) - r_half);
            neg_next = 1'b1;
        end
        else
        begin
            q_next   = 13'(r_half);
            neg_next = 1'b0;
        end
    end

    // stage 2: scale to table entries and drop the power-of-two part
    assign v = QN_W'(q_reg) * QN_W'(COS_TABLE_ENTRIES) + QN_W'(QUARTER_TURN / 2);

    // stage 3: exact division by 45 through its reciprocal
    assign qp = PW'(w_reg) * PW'(RECIP45);

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        neg1_reg <= neg_next;
        w_reg    <= v[QN_W-1:DIV_SHIFT];
        neg2_reg <= neg1_reg;
        idx_reg  <= qp[RECIP45_SHIFT +: IDX_W];
        neg3_reg <= neg2_reg;
    end

    assign idx = idx_reg;
    assign neg = neg3_reg;

endmodule

### design/sofov_cos_rom.sv
// Quarter-wave cosine table in Q1.30 with two registered read ports.
// Depends on sofov_pkg for the cosine series and the table type.
module sofov_cos_rom
    import sofov_pkg::*;
#(
    parameter int COS_TABLE_ENTRIES = 1024
)(
    input  logic                                     clk,
    input  logic [$clog2(COS_TABLE_ENTRIES + 1)-1:0] addr_a,
    input  logic [$clog2(COS_TABLE_ENTRIES + 1)-1:0] addr_b,
    output cos_t                                     data_a,
    output cos_t                                     data_b
);

    localparam int DEPTH = COS_TABLE_ENTRIES + 1;

    cos_t rom [DEPTH];
    cos_t data_a_reg;
    cos_t data_b_reg;

    // entry i holds cos(i * (pi/2) / N)
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_entry
        localparam logic [63:0] XV = (64'(gi) * HALF_PI_Q30) / 64'(COS_TABLE_ENTRIES);
        assign rom[gi] = cos_series(XV);
    end

    // registered reads for azimuth and elevation
    always_ff @(posedge clk)
    begin
        data_a_reg <= rom[addr_a];
        data_b_reg <= rom[addr_b];
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

### design/sofov_pixel.sv
// Screen pixel mapping for both axes, four register stages.
// Depends on sofov_pkg for the view half width.
module sofov_pixel
    import sofov_pkg::*;
(
    input  logic               clk,
    input  logic [11:0]        radius_pixels,
    input  logic signed [14:0] azimuth,
    input  logic signed [13:0] elevation,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y
);

    localparam int PROD_W = 29;
    localparam int MAG_W  = 28;
    // 2560 = 512 * 5: shift by 9, then reciprocal of 5
    localparam int DIV_SHIFT    = 9;
    localparam int SH_W         = MAG_W - DIV_SHIFT;
    localparam logic [63:0] RECIP5 = 64'd3355444;
    localparam int RECIP5_W     = 22;
    localparam int RECIP5_SHIFT = 24;
    localparam int QP_W         = SH_W + RECIP5_W;
    localparam int QUO_W        = QP_W - RECIP5_SHIFT;

    logic signed [12:0]       r_s;
    logic signed [15:0]       tv        [2];
    logic signed [PROD_W-1:0] prod_next [2];
    logic signed [PROD_W-1:0] prod_reg  [2];
    logic [MAG_W-1:0]         mag       [2];
    logic [SH_W-1:0]          sh_reg    [2];
    logic                     neg2_reg  [2];
    logic [QP_W-1:0]          qp        [2];
    logic [QUO_W-1:0]         quo_reg   [2];
    logic                     neg3_reg  [2];
    logic signed [QUO_W:0]    sv        [2];
    logic signed [15:0]       pix_next  [2];
    logic signed [15:0]       pix_reg   [2];

    // lane 0 is x = r*(az + 2560)/2560, lane 1 is y = r*(2560 - el)/2560
    always_comb
    begin
        r_s   = signed'({1'b0, radius_pixels});
        tv[0] = 16'(azimuth) + 16'(FOV_UNITS);
        tv[1] = 16'(FOV_UNITS) - 16'(elevation);
        for (int i = 0; i < 2; i++)
        begin
            prod_next[i] = PROD_W'(r_s) * PROD_W'(tv[i]);
            mag[i] = prod_reg[i][PROD_W-1] ? MAG_W'(-prod_reg[i]) : MAG_W'(prod_reg[i]);
            qp[i]  = QP_W'(sh_reg[i]) * QP_W'(RECIP5);
            // truncation toward zero, then 16-bit saturation
            sv[i]  = neg3_reg[i] ? -signed'({1'b0, quo_reg[i]}) : signed'({1'b0, quo_reg[i]});
            if (sv[i] > (QUO_W + 1)'(32767))
            begin
                pix_next[i] = 16'sh7FFF;
            end
            else if (sv[i] < -(QUO_W + 1)'(32768))
            begin
                pix_next[i] = 16'sh8000;
            end
            else
            begin
                pix_next[i] = sv[i][15:0];
            end
        end
    end

    // product, magnitude, quotient and saturation stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            prod_reg[i] <= prod_next[i];
            sh_reg[i]   <= mag[i][MAG_W-1:DIV_SHIFT];
            neg2_reg[i] <= prod_reg[i][PROD_W-1];
            quo_reg[i]  <= qp[i][QP_W-1:RECIP5_SHIFT];
            neg3_reg[i] <= neg2_reg[i];
            pix_reg[i]  <= pix_next[i];
        end
    end

    assign pixel_x = pix_reg[0];
    assign pixel_y = pix_reg[1];

endmodule

### design/sofov_scale.sv
// Display scale from range: linear ramp from 0.75 to 0.1, five register stages.
// Reciprocal estimate with one remainder check; depends on sofov_pkg.
module sofov_scale
    import sofov_pkg::*;
#(
    parameter int SCALE_FAR_RANGE_M = 2000000
)(
    input  logic        clk,
    input  logic [25:0] range_m,
    output logic [15:0] draw_scale
);

    // scale = floor((1966100*span - 1703936*d) / (40*span)), d = clamped range - near
    localparam longint SPAN  = longint'(SCALE_FAR_RANGE_M) - longint'(SCALE_NEAR_RANGE_M);
    localparam int     D_W   = $clog2(SPAN + 1);
    localparam longint BK    = (longint'(425984) << 32) / (10 * SPAN);
    localparam int     BK_W  = $clog2(BK + 1);
    localparam int     M_W   = D_W + BK_W;
    localparam longint XTOP  = 1966100 * SPAN;
    localparam int     X_W   = $clog2(XTOP + 1);
    localparam longint DEN   = 40 * SPAN;
    localparam int     DEN_W = $clog2(DEN + 1);
    localparam int     P_W   = 16 + DEN_W;
    localparam longint C0    = (longint'(49152) << 32) + (longint'(1) << 31);
    localparam longint D_MUL = 1703936;

    logic [D_W-1:0]   d_next;
    logic [D_W-1:0]   d_reg;
    logic [M_W-1:0]   m_reg;
    logic [X_W-1:0]   x2_reg;
    logic [63:0]      est;
    logic [15:0]      s0_3_reg;
    logic [X_W-1:0]   x3_reg;
    logic [P_W-1:0]   p_reg;
    logic [15:0]      s0_4_reg;
    logic [X_W-1:0]   x4_reg;
    logic [15:0]      scale_reg;

    // stage 1: clamp range to the ramp span
    always_comb
    begin
        if (range_m > 26'(SCALE_FAR_RANGE_M))
        begin
            d_next = D_W'(SPAN);
        end
        else if (range_m < 26'(SCALE_NEAR_RANGE_M))
        begin
            d_next = '0;
        end
        else
        begin
            d_next = D_W'(range_m - 26'(SCALE_NEAR_RANGE_M));
        end
    end

    // stage 3 estimate: at most one above the true quotient
    assign est = 64'(C0) - 64'(m_reg);

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        // stage 2: slope product and exact numerator
        m_reg     <= M_W'(d_reg) * M_W'(BK);
        x2_reg    <= X_W'(XTOP) - X_W'(d_reg) * X_W'(D_MUL);
        s0_3_reg  <= est[47:32];
        x3_reg    <= x2_reg;
        // stage 4: back-multiply the estimate
        p_reg     <= P_W'(s0_3_reg) * P_W'(DEN);
        s0_4_reg  <= s0_3_reg;
        x4_reg    <= x3_reg;
        // stage 5: step down when the estimate overshoots
        scale_reg <= (64'(p_reg) > 64'(x4_reg)) ? s0_4_reg - 16'd1 : s0_4_reg;
    end

    assign draw_scale = scale_reg;

endmodule

### design/sky_object_fov_screen_to_pixel.sv
// Sky object field-of-view screen: range window, 40 degree cone, pixels, scale.
// Uses sofov_pkg, sofov_angle_idx, sofov_cos_rom, sofov_pixel and sofov_scale.
//
// Usage: drive range_m, azimuth and elevation with start high; a transaction
// is taken at every rising edge with start high, since busy stays low and the
// block takes one item per cycle with no gaps. Each result comes back on done
// for one cycle with visible, pixel_x, pixel_y and draw_scale. Results leave in
// order; the receiver cannot stall, so the six-stage pipeline never holds. The
// depth is set by the cone path: angle fold, table index by reciprocal, cosine
// table read, cosine product, threshold compare.
// Configuration: cfg_write with cfg_index and cfg_data writes one register at
// the clock edge (0 max range km, 1 min range km, 2 radius pixels); an index
// of 3 is ignored. Write only while no transaction is in flight.
// Reset clears all in-flight transactions and restores the register defaults
// (2000 km, 200 km, radius 0). The cosine table is a constant, no fill needed.
module sky_object_fov_screen_to_pixel
    import sofov_pkg::*;
#(
    parameter int SCALE_FAR_RANGE_M = 2000000,
    parameter int COS_TABLE_ENTRIES = 1024
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [25:0]        range_m,
    input  logic signed [14:0] azimuth,
    input  logic signed [13:0] elevation,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic               visible,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [15:0]        draw_scale
);

    localparam int IDX_W  = $clog2(COS_TABLE_ENTRIES + 1);
    localparam int LAT    = 6;
    localparam int PROD_W = 2 * COS_W;

    logic [15:0]        max_range_km_reg;
    logic [15:0]        min_range_km_reg;
    logic [11:0]        radius_pixels_reg;
    sofov_cfg_t         cfg;
    logic [LAT-1:0]     valid_reg;
    logic [25:0]        max_m;
    logic [25:0]        min_m;
    logic               in_window;
    logic [LAT-2:0]     win_reg;
    logic [IDX_W-1:0]   idx_az;
    logic [IDX_W-1:0]   idx_el;
    logic               neg_az;
    logic               neg_el;
    logic               neg_az_reg;
    logic               neg_el_reg;
    cos_t               cos_az;
    cos_t               cos_el;
    logic [PROD_W-1:0]  prod_reg;
    logic               same_sign_reg;
    logic               visible_reg;
    logic signed [15:0] px4;
    logic signed [15:0] py4;
    logic signed [15:0] px5_reg;
    logic signed [15:0] py5_reg;
    logic signed [15:0] pixel_x_reg;
    logic signed [15:0] pixel_y_reg;
    logic [15:0]        scale5;
    logic [15:0]        draw_scale_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_km_reg  <= 16'd2000;
            min_range_km_reg  <= 16'd200;
            radius_pixels_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_RANGE_KM:  max_range_km_reg  <= cfg_data;
                CFG_MIN_RANGE_KM:  min_range_km_reg  <= cfg_data;
                CFG_RADIUS_PIXELS: radius_pixels_reg <= cfg_data[11:0];
                default:           ;
            endcase
        end
    end

    assign cfg.max_range_km  = max_range_km_reg;
    assign cfg.min_range_km  = min_range_km_reg;
    assign cfg.radius_pixels = radius_pixels_reg;

    // one transaction per cycle, never held off
    assign busy = 1'b0;

    // valid bits travel alongside the data stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], start && !busy};
        end
    end

    // range window in meters; an inverted window passes nothing
    assign max_m     = 26'(cfg.max_range_km) * 26'(KM_TO_M);
    assign min_m     = 26'(cfg.min_range_km) * 26'(KM_TO_M);
    assign in_window = (range_m <= max_m) && (range_m >= min_m);

    // table index for each angle, ready at stage 3
    sofov_angle_idx #(
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_az_idx (
        .clk   (clk),
        .angle (azimuth),
        .idx   (idx_az),
        .neg   (neg_az)
    );

    sofov_angle_idx #(
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_el_idx (
        .clk   (clk),
        .angle (15'(elevation)),
        .idx   (idx_el),
        .neg   (neg_el)
    );

    // cosine magnitudes, ready at stage 4
    sofov_cos_rom #(
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_cos_rom (
        .clk    (clk),
        .addr_a (idx_az),
        .addr_b (idx_el),
        .data_a (cos_az),
        .data_b (cos_el)
    );

    // pixel coordinates, ready at stage 4
    sofov_pixel u_pixel (
        .clk           (clk),
        .radius_pixels (cfg.radius_pixels),
        .azimuth       (azimuth),
        .elevation     (elevation),
        .pixel_x       (px4),
        .pixel_y       (py4)
    );

    // draw scale, ready at stage 5
    sofov_scale #(
        .SCALE_FAR_RANGE_M (SCALE_FAR_RANGE_M)
    ) u_scale (
        .clk        (clk),
        .range_m    (range_m),
        .draw_scale (scale5)
    );

    // data stages: window delay, cone product and compare, output alignment
    always_ff @(posedge clk)
    begin
        win_reg        <= {win_reg[LAT-3:0], in_window};
        neg_az_reg     <= neg_az;
        neg_el_reg     <= neg_el;
        // a product of opposite signs is never above the positive threshold
        prod_reg       <= PROD_W'(cos_az) * PROD_W'(cos_el);
        same_sign_reg  <= (neg_az_reg == neg_el_reg);
        visible_reg    <= win_reg[LAT-2] && same_sign_reg &&
                          (prod_reg >= (PROD_W'(CONE_THRESHOLD) << 30));
        px5_reg        <= px4;
        py5_reg        <= py4;
        pixel_x_reg    <= px5_reg;
        pixel_y_reg    <= py5_reg;
        draw_scale_reg <= scale5;
    end

    assign done       = valid_reg[LAT-1];
    assign visible    = visible_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign draw_scale = draw_scale_reg;

endmodule

### sim/tb_sky_object_fov_screen_to_pixel.sv
// Testbench for sky_object_fov_screen_to_pixel: directed and random sky objects
// checked against an in-bench model of the range window, view cone, pixels and scale.
// Depends on sofov_pkg and the design sources; needs no files or arguments.
module tb_sky_object_fov_screen_to_pixel
    import sofov_pkg::*;
();

    localparam int FAR_RANGE_M  = 2000000;
    localparam int COS_ENTRIES  = 1024;
    localparam int RANGE_TOP    = (1 << 26) - 1;
    localparam int PIPE_DRAIN   = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_PRINTED  = 40;
    localparam int RANDOM_SETS  = 5;
    localparam int SET_ITEMS    = 110;
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    typedef longint unsigned u64_t;

    // one expected screen transaction, with the object that caused it
    typedef struct {
        logic [25:0] obj_range;
        int          obj_az;
        int          obj_el;
        logic        visible;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] draw_scale;
    } screen_expect_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    logic [25:0]        range_m    = '0;
    logic signed [14:0] azimuth    = '0;
    logic signed [13:0] elevation  = '0;
    logic               cfg_write  = 1'b0;
    logic [1:0]         cfg_index  = CFG_MAX_RANGE_KM;
    logic [15:0]        cfg_data   = '0;
    logic               done;
    logic               visible;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [15:0]        draw_scale;

    // bench copy of the registers, at their reset values
    logic [15:0] max_km = 16'd2000;
    logic [15:0] min_km = 16'd200;
    logic [11:0] radius = 12'd0;

    u64_t cos_q30 [0:COS_ENTRIES];
    u64_t cone_limit;

    screen_expect_t expected_screens[$];
    int err_count      = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int visible_count  = 0;
    int setting_count  = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    bit back_to_back   = 1'b0;

    sky_object_fov_screen_to_pixel dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .range_m    (range_m),
        .azimuth    (azimuth),
        .elevation  (elevation),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .visible    (visible),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .draw_scale (draw_scale)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // truncated Taylor series of cos in Q30, seven Horner steps, floored at zero
    function automatic u64_t cos_taylor(u64_t x);
        u64_t x2;
        u64_t t;
        u64_t p;
        int k;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (k = 7; k >= 1; k--)
        begin
            p = ((x2 * t) >> 30) / u64_t'(2 * k * (2 * k - 1));
            t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        end
        return t;
    endfunction

    // signed cosine of an angle in 1/64 degree, periodic over a full turn
    function automatic longint cos_at(longint a);
        longint          r;
        u64_t            idx;
        bit              neg;
        neg = 1'b0;
        r = a % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        if (r > HALF_TURN)
            r = FULL_TURN - r;
        if (r > QUARTER_TURN)
        begin
            r   = HALF_TURN - r;
            neg = 1'b1;
        end
        idx = (u64_t'(r) * COS_ENTRIES + QUARTER_TURN / 2) / QUARTER_TURN;
        if (idx > COS_ENTRIES)
            idx = COS_ENTRIES;
        return neg ? -longint'(cos_q30[idx]) : longint'(cos_q30[idx]);
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // expected screen result for one object under the current registers
    function automatic screen_expect_t predict_screen(logic [25:0] rng,
                                                      logic signed [14:0] az,
                                                      logic signed [13:0] el);
        screen_expect_t res;
        longint a;
        longint e;
        longint rad;
        longint c;
        longint span;
        longint num;
        longint den;
        longint s;
        a   = az;
        e   = el;
        rad = radius;
        res.obj_range = rng;
        res.obj_az    = int'(a);
        res.obj_el    = int'(e);
        res.visible   = 1'b1;
        if (longint'(rng) > longint'(max_km) * KM_TO_M)
            res.visible = 1'b0;
        if (longint'(rng) < longint'(min_km) * KM_TO_M)
            res.visible = 1'b0;
        if (cos_at(a) * cos_at(e) < longint'(cone_limit) * longint'(ONE_Q30))
            res.visible = 1'b0;
        res.pixel_x = clamp16((rad * (a + FOV_UNITS)) / FOV_UNITS);
        res.pixel_y = clamp16((rad * (FOV_UNITS - e)) / FOV_UNITS);
        // linear scale over the clamped range, rounded to nearest
        c = longint'(rng);
        if (c > FAR_RANGE_M)
            c = FAR_RANGE_M;
        if (c < SCALE_NEAR_RANGE_M)
            c = SCALE_NEAR_RANGE_M;
        span = FAR_RANGE_M - SCALE_NEAR_RANGE_M;
        num  = 65536 * (15 * span - 13 * (c - SCALE_NEAR_RANGE_M));
        den  = 20 * span;
        s    = (2 * num + den) / (2 * den);
        if (s > 65535)
            s = 65535;
        res.draw_scale = s[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // result check and transaction capture, both sampled at the rising edge
    always @(posedge clk)
    begin : result_check
        screen_expect_t want;
        if (rst_n)
        begin
            if (done)
            begin
                result_count++;
                if (expected_screens.size() == 0)
                    report_mismatch("result with no transaction pending");
                else
                begin
                    want = expected_screens.pop_front();
                    if (visible)
                        visible_count++;
                    if (visible !== want.visible)
                        report_mismatch($sformatf("visible %b want %b (r=%0d az=%0d el=%0d)",
                            visible, want.visible, want.obj_range, want.obj_az, want.obj_el));
                    if (pixel_x !== want.pixel_x)
                        report_mismatch($sformatf("pixel_x %0d want %0d (az=%0d)",
                            pixel_x, $signed(want.pixel_x), want.obj_az));
                    if (pixel_y !== want.pixel_y)
                        report_mismatch($sformatf("pixel_y %0d want %0d (el=%0d)",
                            pixel_y, $signed(want.pixel_y), want.obj_el));
                    if (draw_scale !== want.draw_scale)
                        report_mismatch($sformatf("draw_scale %0d want %0d (r=%0d)",
                            draw_scale, want.draw_scale, want.obj_range));
                end
            end
            if (start && !busy)
            begin
                expected_screens.insert(expected_screens.size(),
                                        predict_screen(range_m, azimuth, elevation));
                accepted_count++;
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sender bursts of random length with random gaps
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            if (!back_to_back)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // offer one object and return at the edge that takes it
    task automatic send_object(logic [25:0] rng, logic signed [14:0] az,
                               logic signed [13:0] el);
        bit taken;
        pace_sender();
        start     <= 1'b1;
        range_m   <= rng;
        azimuth   <= az;
        elevation <= el;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_screens.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MAX_RANGE_KM:  max_km = value;
            CFG_MIN_RANGE_KM:  min_km = value;
            CFG_RADIUS_PIXELS: radius = value[11:0];
            default: ;
        endcase
        setting_count++;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_window(int hi_km, int lo_km, int rad);
        write_register(CFG_MAX_RANGE_KM, 16'(hi_km));
        write_register(CFG_MIN_RANGE_KM, 16'(lo_km));
        write_register(CFG_RADIUS_PIXELS, 16'(rad));
    endtask

    // range picks clustered on the window edges and the scale span
    function automatic logic [25:0] pick_range();
        longint v;
        longint lo;
        longint hi;
        lo = longint'(min_km) * KM_TO_M;
        hi = longint'(max_km) * KM_TO_M;
        case ($urandom_range(0, 7))
            0: v = lo + $urandom_range(0, 6) - 3;
            1: v = hi + $urandom_range(0, 6) - 3;
            2: v = $urandom_range(SCALE_NEAR_RANGE_M - 2000, FAR_RANGE_M + 2000);
            3: v = $urandom_range(0, RANGE_TOP);
            default:
                if (lo <= hi)
                    v = lo + longint'($urandom_range(0, int'(hi - lo)));
                else
                    v = $urandom_range(0, RANGE_TOP);
        endcase
        if (v < 0)
            v = 0;
        if (v > RANGE_TOP)
            v = RANGE_TOP;
        return v[25:0];
    endfunction

    // angles mostly around the view cone, some on its edge, some anywhere
    function automatic int pick_angle(int field_half);
        case ($urandom_range(0, 9))
            0, 1:    return ($urandom_range(0, 1) ? FOV_UNITS : -FOV_UNITS)
                            + $urandom_range(0, 80) - 40;
            2:       return $urandom_range(0, 2 * field_half - 1) - field_half;
            default: return $urandom_range(0, 2 * 3840) - 3840;
        endcase
    endfunction

    // register defaults straight after reset
    task automatic test_reset_defaults();
        send_object(26'(SCALE_NEAR_RANGE_M), 15'sd0, 14'sd0);
        send_object(26'(SCALE_NEAR_RANGE_M - 1), 15'sd0, 14'sd0);
        send_object(26'(FAR_RANGE_M), 15'sd0, 14'sd0);
        send_object(26'(FAR_RANGE_M + 1), 15'sd0, 14'sd0);
        send_object(26'd0, 15'sd0, 14'sd0);
        send_object(26'(RANGE_TOP), 15'sd0, 14'sd0);
    endtask

    // field extremes, the cone edge and angles past the nominal span
    task automatic test_field_extremes();
        set_window(65535, 0, 0);
        write_register(CFG_RADIUS_PIXELS, 16'hFFFF);
        send_object(26'd1100000, -15'sd16384, -14'sd8192);
        send_object(26'd1100000, 15'sd16383, 14'sd8191);
        send_object(26'd1100000, -15'sd11520, 14'sd5760);
        send_object(26'd1100000, 15'sd11520, -14'sd5760);
        send_object(26'd1100000, 15'sd2560, 14'sd0);
        send_object(26'd1100000, 15'sd0, -14'sd2560);
        send_object(26'd1100000, 15'sd1792, 14'sd1792);
        send_object(26'd1100000, -15'sd1900, 14'sd1900);
        send_object(26'h2AAAAAA, 15'sd0, 14'sd0);
        send_object(26'h1555555, 15'sd0, 14'sd0);
    endtask

    // inverted and single-point windows, and the unused index
    task automatic test_range_window();
        set_window(1000, 3000, 640);
        send_object(26'd2000000, 15'sd0, 14'sd0);
        set_window(500, 500, 640);
        send_object(26'd500000, 15'sd100, 14'sd100);
        send_object(26'd499999, 15'sd0, 14'sd0);
        send_object(26'd500001, 15'sd0, 14'sd0);
        set_window(0, 0, 640);
        send_object(26'd0, 15'sd0, 14'sd0);
        send_object(26'd1, 15'sd0, 14'sd0);
        set_window(65535, 65535, 640);
        write_register(CFG_SPARE_INDEX, 16'h0001);
        send_object(26'd65535000, 15'sd0, 14'sd0);
        send_object(26'(RANGE_TOP), 15'sd0, 14'sd0);
    endtask

    // mostly plausible objects with some full-field noise, over several settings
    task automatic test_random_objects();
        int set_no;
        int n;
        for (set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            case (set_no)
                0: set_window(2000, 200, $urandom_range(0, 4095));
                1: set_window(65535, 0, 4095);
                2: set_window($urandom_range(0, 65535), $urandom_range(0, 65535), 0);
                3: set_window($urandom_range(1000, 3000), $urandom_range(0, 800),
                              $urandom_range(0, 4095));
                default: set_window($urandom_range(100, 900), $urandom_range(1000, 5000),
                                    $urandom_range(1, 4095));
            endcase
            back_to_back = (set_no == 1);
            for (n = 0; n < SET_ITEMS; n++)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_object(26'($urandom_range(0, RANGE_TOP)),
                                15'($urandom_range(0, 32767)),
                                14'($urandom_range(0, 16383)));
                else
                    send_object(pick_range(), 15'(pick_angle(16384)),
                                14'(pick_angle(8192)));
            end
        end
        back_to_back = 1'b0;
    endtask

    initial
    begin : run_tests
        int i;
        for (i = 0; i <= COS_ENTRIES; i++)
            cos_q30[i] = cos_taylor(u64_t'(i) * HALF_PI_Q30 / COS_ENTRIES);
        cone_limit = cos_taylor(HALF_PI_Q30 * 4 / 9);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_range_window();
        test_random_objects();

        // drain the pipeline, then wait for stragglers
        wait_drained();
        repeat (PIPE_DRAIN) @(posedge clk);
        if (expected_screens.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_screens.size()));

        $display("Run covered %0d objects and %0d results (%0d visible)",
                 accepted_count, result_count, visible_count);
        $display("over %0d register writes, with %0d mismatches", setting_count, err_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
